// File: hdl/pltd_pkg.sv
// shared types, constants and helpers for the planar tile dedup encoder
`timescale 1ns / 1ps

package pltd_pkg;

  // capacity of the unique tile store, in tiles
  localparam int MAX_TILES = 1024;

  // geometry of one cell
  localparam int ROWS     = 8;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int PIX_W    = 4;
  localparam int WORD_W   = 32;

  // width of the tile index field on the result port
  localparam int IDX_W    = 10;

  // store addressing and tile counting
  localparam int TILE_W   = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CNT_W    = $clog2(MAX_TILES + 1);
  localparam int ADDR_W   = TILE_W + ROW_W;
  localparam int DEPTH    = MAX_TILES * ROWS;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  // one row of palette indices, element 0 is the leftmost pixel
  typedef logic [ROWS-1:0][PIX_W-1:0] row_pix_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_ROWS   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_STORE  = 4'b0100,
    ST_MAP    = 4'b1000
  } state_t;

  // access request to the tile store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  // pack one row into planar form: plane p in byte p, leftmost pixel in the msb
  function automatic logic [WORD_W-1:0] pack_row(input row_pix_t pix);
    logic [WORD_W-1:0] word;
    word = '0;
    for (int col = 0; col < ROWS; col++) begin
      for (int p = 0; p < PIX_W; p++) begin
        word[p * 8 + (ROWS - 1 - col)] = pix[col][p];
      end
    end
    return word;
  endfunction

  // tile number as it shows on the result port, low bits kept
  function automatic logic [IDX_W-1:0] out_index(input logic [CNT_W-1:0] u);
    logic [CNT_W+IDX_W-1:0] wide;
    wide = (CNT_W + IDX_W)'(u);
    return wide[IDX_W-1:0];
  endfunction

endpackage

// File: hdl/planar_tile_dedup_encoder.sv
// top level: row intake, tile search sequencer and result register
`timescale 1ns / 1ps

// Rows are taken one per cycle while in_stall is low; the first seven rows
// of a cell give no result. After the eighth row the block stalls its input
// and searches the tile store, reading one stored row word per cycle through
// a single read port and comparing it with the buffered cell in a single
// 32-bit comparator. A stored tile that differs in its first row is left
// after that first compare; a full compare reads all eight of its rows. A
// new tile then has its eight row words written and emitted, followed by the
// map entry; both wait while the result side stalls. A matched or overflowed
// tile gives only the map entry. Rows of the next cell are accepted as soon
// as the map entry is in the output register.

module planar_tile_dedup_encoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [3:0]                   in_pixel_0,
  input  logic [3:0]                   in_pixel_1,
  input  logic [3:0]                   in_pixel_2,
  input  logic [3:0]                   in_pixel_3,
  input  logic [3:0]                   in_pixel_4,
  input  logic [3:0]                   in_pixel_5,
  input  logic [3:0]                   in_pixel_6,
  input  logic [3:0]                   in_pixel_7,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_kind,
  output logic [pltd_pkg::WORD_W-1:0]  out_planar_word,
  output logic [pltd_pkg::IDX_W-1:0]   out_tile_index,
  output logic                         out_is_new,
  output logic                         out_overflow,
  output logic                         out_last
);
  import pltd_pkg::*;

  // control state
  state_t             state_r, state_nxt;
  logic [ROW_W-1:0]   row_cnt_r, row_cnt_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   iu_r, iu_nxt;
  logic [ROW_W-1:0]   ir_r, ir_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0]   cmp_u_r, cmp_u_nxt;
  logic [ROW_W-1:0]   cmp_r_r, cmp_r_nxt;
  logic [ROW_W-1:0]   wr_r, wr_nxt;
  logic               out_valid_r, out_valid_nxt;

  // pending map entry
  logic [IDX_W-1:0]   map_idx_r, map_idx_nxt;
  logic               map_new_r, map_new_nxt;
  logic               map_ovf_r, map_ovf_nxt;

  // result payload
  logic               out_kind_r, out_kind_nxt;
  logic [WORD_W-1:0]  out_word_r, out_word_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic               out_new_r, out_new_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               out_last_r, out_last_nxt;

  // datapath links
  row_pix_t           pix;
  logic               row_we;
  logic [ROW_W-1:0]   row_ridx;
  logic [WORD_W-1:0]  row_rdata;
  store_req_t         st_req;
  logic [WORD_W-1:0]  st_rdata;
  logic               words_eq;
  logic               out_free;

  assign pix = {in_pixel_7, in_pixel_6, in_pixel_5, in_pixel_4,
                in_pixel_3, in_pixel_2, in_pixel_1, in_pixel_0};

  assign in_stall = (state_r != ST_ROWS);
  assign row_we   = in_valid && (state_r == ST_ROWS);
  assign row_ridx = (state_r == ST_STORE) ? wr_r : cmp_r_r;
  assign out_free = !out_valid_r || !out_stall;

  // the one shared comparator
  assign words_eq = (st_rdata == row_rdata);

  pltd_row_buf u_row_buf (
    .clk   (clk),
    .we    (row_we),
    .widx  (row_cnt_r),
    .pix   (pix),
    .ridx  (row_ridx),
    .rdata (row_rdata)
  );

  // store access: reads follow the search pointer, writes follow the store step
  always_comb begin
    st_req.we    = (state_r == ST_STORE) && out_free;
    st_req.waddr = {cnt_r[TILE_W-1:0], wr_r};
    st_req.wdata = row_rdata;
    st_req.raddr = {iu_r[TILE_W-1:0], ir_r};
  end

  pltd_tile_store u_tile_store (
    .clk   (clk),
    .req   (st_req),
    .rdata (st_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    cnt_nxt       = cnt_r;
    iu_nxt        = iu_r;
    ir_nxt        = ir_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_u_nxt     = cmp_u_r;
    cmp_r_nxt     = cmp_r_r;
    wr_nxt        = wr_r;
    map_idx_nxt   = map_idx_r;
    map_new_nxt   = map_new_r;
    map_ovf_nxt   = map_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_new_nxt   = out_new_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      // collect eight rows
      ST_ROWS: begin
        if (in_valid) begin
          row_cnt_nxt = row_cnt_r + 1'b1;
          if (row_cnt_r == ROW_LAST) begin
            state_nxt   = ST_SEARCH;
            iu_nxt      = '0;
            ir_nxt      = '0;
            cmp_vld_nxt = 1'b0;
          end
        end
      end

      // linear search, one stored word read and compared per cycle
      ST_SEARCH: begin
        if (cmp_vld_r && words_eq && (cmp_r_r == ROW_LAST)) begin
          // whole tile matched
          state_nxt   = ST_MAP;
          cmp_vld_nxt = 1'b0;
          map_idx_nxt = out_index(cmp_u_r);
          map_new_nxt = 1'b0;
          map_ovf_nxt = 1'b0;
        end else if (cmp_vld_r && !words_eq) begin
          // mismatch: drop the read in flight, go to the next tile
          cmp_vld_nxt = 1'b0;
          iu_nxt      = cmp_u_r + 1'b1;
          ir_nxt      = '0;
        end else if (iu_r < cnt_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_u_nxt   = iu_r;
          cmp_r_nxt   = ir_r;
          ir_nxt      = ir_r + 1'b1;
          if (ir_r == ROW_LAST) begin
            iu_nxt = iu_r + 1'b1;
          end
        end else begin
          // every stored tile checked without a match
          cmp_vld_nxt = 1'b0;
          if (cnt_r >= CNT_W'(MAX_TILES)) begin
            state_nxt   = ST_MAP;
            map_idx_nxt = '0;
            map_new_nxt = 1'b0;
            map_ovf_nxt = 1'b1;
          end else begin
            state_nxt = ST_STORE;
            wr_nxt    = '0;
          end
        end
      end

      // write the new tile and emit its row words
      ST_STORE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b0;
          out_word_nxt  = row_rdata;
          out_idx_nxt   = out_index(cnt_r);
          out_new_nxt   = 1'b1;
          out_ovf_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          wr_nxt        = wr_r + 1'b1;
          if (wr_r == ROW_LAST) begin
            state_nxt   = ST_MAP;
            cnt_nxt     = cnt_r + 1'b1;
            map_idx_nxt = out_index(cnt_r);
            map_new_nxt = 1'b1;
            map_ovf_nxt = 1'b0;
          end
        end
      end

      // closing map entry
      ST_MAP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b1;
          out_word_nxt  = '0;
          out_idx_nxt   = map_idx_r;
          out_new_nxt   = map_new_r;
          out_ovf_nxt   = map_ovf_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_ROWS;
        end
      end

      default: begin
        state_nxt = ST_ROWS;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ROWS;
      row_cnt_r   <= '0;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // pointers and payload
  always_ff @(posedge clk) begin
    iu_r       <= iu_nxt;
    ir_r       <= ir_nxt;
    cmp_u_r    <= cmp_u_nxt;
    cmp_r_r    <= cmp_r_nxt;
    wr_r       <= wr_nxt;
    map_idx_r  <= map_idx_nxt;
    map_new_r  <= map_new_nxt;
    map_ovf_r  <= map_ovf_nxt;
    out_kind_r <= out_kind_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_new_r  <= out_new_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_planar_word = out_word_r;
  assign out_tile_index  = out_idx_r;
  assign out_is_new      = out_new_r;
  assign out_overflow    = out_ovf_r;
  assign out_last        = out_last_r;

  // store never counts past its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TILES))
    else $error("unique tile count beyond capacity");

  // a compare in flight only exists during the search
  a_cmp_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (state_r == ST_SEARCH))
    else $error("compare pending outside search");

  // overflow only on a map entry that stored nothing
  a_ovf_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (out_kind_r && out_last_r && !out_new_r
                                    && (out_idx_r == '0)))
    else $error("bad overflow entry");

  // row words belong to a stored tile and never end the run
  a_row_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_kind_r) |-> (out_new_r && !out_last_r && !out_ovf_r))
    else $error("bad row word result");

  // storing the last row bumps the tile count
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_STORE) && out_free && (wr_r == ROW_LAST))
      |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("tile count not advanced after store");

endmodule

// File: hdl/pltd_row_buf.sv
// row buffer: packs incoming rows to planar words and holds the current cell
`timescale 1ns / 1ps

module pltd_row_buf (
  input  logic                     clk,
  input  logic                     we,
  input  logic [pltd_pkg::ROW_W-1:0]  widx,
  input  pltd_pkg::row_pix_t        pix,
  input  logic [pltd_pkg::ROW_W-1:0]  ridx,
  output logic [pltd_pkg::WORD_W-1:0] rdata
);
  import pltd_pkg::*;

  logic [WORD_W-1:0] rows_r [ROWS];

  // planar packing on the way in
  always_ff @(posedge clk) begin
    if (we) begin
      rows_r[widx] <= pack_row(pix);
    end
  end

  // single read port
  assign rdata = rows_r[ridx];

endmodule

// File: hdl/pltd_tile_store.sv
// unique tile store: one write port and one registered read port
`timescale 1ns / 1ps

module pltd_tile_store (
  input  logic                       clk,
  input  pltd_pkg::store_req_t        req,
  output logic [pltd_pkg::WORD_W-1:0] rdata
);
  import pltd_pkg::*;

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // write side
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[req.raddr];
  end

  assign rdata = rdata_r;

endmodule
